FILE: sv/psrf_pkg.sv
// Shared types, widths and the slot lookup table for the potentiometer scan filter.
// No dependencies; used by psrf_out_fifo and pot_scan_reversal_filter.
`timescale 1ns / 1ps
`default_nettype none

package psrf_pkg;

    localparam int NumParams = 32;
    localparam int ParamIdxW = $clog2(NumParams);
    localparam int LevelW    = 7;
    localparam int ChipW     = 2;
    localparam int StepW     = 3;
    localparam int RawW      = 10;
    localparam int SlotW     = StepW + 1;
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [LevelW-1:0] LevelMax = 7'd127;

    // One stored entry per parameter: direction of last change and last level.
    typedef struct packed {
        logic              rising;
        logic [LevelW-1:0] level;
    } t_entry;

    // One result beat.
    typedef struct packed {
        logic [LevelW-1:0]    value;
        logic [ParamIdxW-1:0] index;
    } t_result;

    typedef struct packed {
        logic [FifoCntW-1:0] count;
        logic                full;
    } t_fifo_status;

    // Slot to logical parameter number within one pair of chips.
    function automatic logic [SlotW-1:0] slot_param(input logic [SlotW-1:0] slot);
        logic [SlotW-1:0] p;
        case (slot)
            4'd0:    p = 4'd7;
            4'd1:    p = 4'd6;
            4'd2:    p = 4'd5;
            4'd3:    p = 4'd3;
            4'd4:    p = 4'd0;
            4'd5:    p = 4'd2;
            4'd6:    p = 4'd4;
            4'd7:    p = 4'd1;
            4'd8:    p = 4'd14;
            4'd9:    p = 4'd13;
            4'd10:   p = 4'd12;
            4'd11:   p = 4'd15;
            4'd12:   p = 4'd8;
            4'd13:   p = 4'd11;
            4'd14:   p = 4'd9;
            default: p = 4'd10;
        endcase
        return p;
    endfunction

    // Slots whose pot is wired reversed.
    function automatic logic slot_invert(input logic [SlotW-1:0] slot);
        logic inv;
        case (slot) inside
            4'd3, 4'd4, 4'd5, 4'd7, [4'd12:4'd15]: inv = 1'b1;
            default:                               inv = 1'b0;
        endcase
        return inv;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pot_scan_reversal_filter.sv
// Top level of the potentiometer scan filter: slot lookup, parameter store, reporting.
// Depends on psrf_pkg and psrf_out_fifo.
//
// Usage:
//   Slave stream takes one pot sample per beat: chip select, scan step and the
//   10-bit converter reading. The master stream carries one beat per reported
//   change: parameter number and its new 7-bit value. Samples that leave the
//   value unchanged, that reverse direction, or that arrive while reporting is
//   disabled give no beat; the stored state is updated in every case.
//   i_cfg_wr_en / i_cfg_wr_data write the report enable bit (reset value 0).
// Pipeline and throughput:
//   One sample per cycle is sustained while the output queue has room. A reported
//   change passes the synchronous read of the parameter RAM, then the compare and
//   write back, then the output queue before it shows on the master side.
//   The read-modify-write loop on that single RAM sets the rate; a one-deep bypass
//   of the last write lets back-to-back samples on the same parameter see fresh data.
// Reset:
//   Synchronous, active low. A per-entry valid bit is cleared at once, so every
//   parameter reads as level 0, falling, with no clearing sweep.
// Stall:
//   Results queue in a four-beat buffer. The slave side drops tready only when
//   that buffer plus the sample in flight could fill it; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module pot_scan_reversal_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: report_enable
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    // Samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [1:0] chip_select, [4:2] scan_step,
                                             // [14:5] raw_sample, [15] zero
    // Reported changes
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [4:0] param_index, [11:5] param_value,
                                             // [15:12] zero
);

    localparam int IdxW = psrf_pkg::ParamIdxW;
    localparam int LvlW = psrf_pkg::LevelW;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic r_report_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_report_enable <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: decode the sample, look up the slot, issue the RAM read
    // ---------------------------------------------------------------------
    logic [psrf_pkg::ChipW-1:0] s0_chip;
    logic [psrf_pkg::StepW-1:0] s0_step;
    logic [psrf_pkg::RawW-1:0]  s0_raw;
    logic [psrf_pkg::SlotW-1:0] s0_slot;
    logic [IdxW-1:0]            s0_addr;
    logic [LvlW-1:0]            s0_level;
    logic [LvlW-1:0]            s0_value;
    logic                       in_accept;

    assign s0_chip  = s_axis_tdata[1:0];
    assign s0_step  = s_axis_tdata[4:2];
    assign s0_raw   = s_axis_tdata[14:5];
    assign s0_slot  = {s0_chip[0], s0_step};
    // Chip bit 1 selects the upper half of the parameter space.
    assign s0_addr  = {s0_chip[1], psrf_pkg::slot_param(s0_slot)};
    // Drop the three low converter bits.
    assign s0_level = s0_raw[psrf_pkg::RawW-1 -: LvlW];
    assign s0_value = psrf_pkg::slot_invert(s0_slot) ? (psrf_pkg::LevelMax - s0_level)
                                                     : s0_level;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------------
    // Parameter store
    // ---------------------------------------------------------------------
    psrf_pkg::t_entry r_store [psrf_pkg::NumParams];
    psrf_pkg::t_entry r_rd_data;
    logic [psrf_pkg::NumParams-1:0] r_entry_valid;

    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    psrf_pkg::t_entry wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= r_store[s0_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (wr_en) begin
            r_entry_valid[wr_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: merge bypass, compare, write back, queue the result
    // ---------------------------------------------------------------------
    logic             r_s1_valid;
    logic [IdxW-1:0]  r_s1_addr;
    logic [LvlW-1:0]  r_s1_value;

    // Last write, registered: the read issued in the same cycle as that write missed it.
    logic             r_wb_valid;
    logic [IdxW-1:0]  r_wb_addr;
    psrf_pkg::t_entry r_wb_data;

    psrf_pkg::t_entry cur;
    logic             changed;
    logic             up;
    logic             push;
    psrf_pkg::t_result push_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_wb_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr  <= s0_addr;
            r_s1_value <= s0_value;
        end
        r_wb_addr <= wr_addr;
        r_wb_data <= wr_data;
    end

    always_comb begin
        // Bypass beats RAM; an entry never written reads as reset state.
        if (r_wb_valid && (r_wb_addr == r_s1_addr)) begin
            cur = r_wb_data;
        end else if (r_entry_valid[r_s1_addr]) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    assign changed = (r_s1_value != cur.level);
    assign up      = (r_s1_value > cur.level);

    always_comb begin
        wr_en          = r_s1_valid;
        wr_addr        = r_s1_addr;
        wr_data.level  = r_s1_value;
        wr_data.rising = cur.rising;
        push           = 1'b0;
        if (changed) begin
            if (up == cur.rising) begin
                push = r_s1_valid && r_report_enable;
            end else begin
                // Reversal: record direction, hold the report.
                wr_data.rising = up;
            end
        end
    end

    assign push_data.index = r_s1_addr;
    assign push_data.value = r_s1_value;

    // ---------------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------------
    psrf_pkg::t_result      pop_data;
    psrf_pkg::t_fifo_status fifo_status;
    logic [psrf_pkg::FifoCntW:0] committed;

    psrf_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_pop_data  (pop_data),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_status    (fifo_status)
    );

    // Count the sample in flight as a possible result.
    assign committed     = {1'b0, fifo_status.count} + {{psrf_pkg::FifoCntW{1'b0}}, r_s1_valid};
    assign s_axis_tready = (committed < (psrf_pkg::FifoCntW + 1)'(psrf_pkg::FifoDepth));

    assign m_axis_tdata = {4'b0000, pop_data.value, pop_data.index};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_status.full)
        else $error("result pushed into a full queue");

    a_wb_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> (r_wb_valid && (r_wb_addr == $past(r_s1_addr))))
        else $error("bypass register lost the last write");

    a_quiet_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_report_enable) |-> !push)
        else $error("report while reporting disabled");

    a_report_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (changed && (wr_data.rising == cur.rising)))
        else $error("report without a same-direction change");

endmodule

`default_nettype wire

FILE: sv/psrf_out_fifo.sv
// Small result queue that decouples the filter pipeline from the output stall.
// Depends on psrf_pkg for the result type, depth and status struct.
`timescale 1ns / 1ps
`default_nettype none

module psrf_out_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  psrf_pkg::t_result           i_push_data,
    output psrf_pkg::t_result           o_pop_data,
    output logic                        o_valid,
    input  wire logic                   i_pop_ready,
    output psrf_pkg::t_fifo_status      o_status
);

    psrf_pkg::t_result                    r_mem [psrf_pkg::FifoDepth];
    logic [psrf_pkg::FifoPtrW-1:0]        r_wr_ptr;
    logic [psrf_pkg::FifoPtrW-1:0]        r_rd_ptr;
    logic [psrf_pkg::FifoCntW-1:0]        r_count;
    logic [psrf_pkg::FifoCntW-1:0]        n_count;
    logic                                 pop;

    assign o_valid    = (r_count != '0);
    assign pop        = o_valid && i_pop_ready;
    assign o_pop_data = r_mem[r_rd_ptr];

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == psrf_pkg::FifoCntW'(psrf_pkg::FifoDepth));

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
